/* rtl/tsdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsdc_pkg
// Shared types and constants of the two-sensor direction counter: the
// classified scan that travels from front to back, the result beat, and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package tsdc_pkg;

    // Configuration port geometry
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam int unsigned THR_W  = 7;

    // Register indexes as seen on paddr[2]
    localparam logic REG_HIGH_THRESHOLD = 1'b0;
    localparam logic REG_LOW_THRESHOLD  = 1'b1;

    // Reset values of the thresholds, in percent
    localparam logic [THR_W-1:0] HIGH_THR_RESET = 7'd70;
    localparam logic [THR_W-1:0] LOW_THR_RESET  = 7'd30;

    // floor(sample*39/100) as (sample*PCT_MUL) >> PCT_SHIFT, exact for 8-bit samples
    localparam int unsigned PCT_SHIFT = 19;
    localparam logic [17:0] PCT_MUL   = 18'd204477;

    // Largest decimal digit
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // One sensor judged against both thresholds
    typedef struct packed {
        logic above;   // percent above the high threshold
        logic below;   // percent below the low threshold
    } t_judge;

    // Classified scan, front to back
    typedef struct packed {
        t_judge judge_a;
        t_judge judge_b;
        logic   clear_press;
        logic   down_press;
        logic   up_press;
    } t_scan;

    // Count kept as two BCD digits
    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_bcd;

    // Result beat
    typedef struct packed {
        logic [3:0] tens_digit;
        logic [3:0] units_digit;
        logic       obstacle_lamp;
        logic       relay_on;
        logic       store_strobe;
    } t_result;

    // Count up with wrap from 99 to 0
    function automatic t_bcd bcd_up(input t_bcd c);
        t_bcd r;
        r = c;
        if (c.units == DIGIT_MAX) begin
            r.units = 4'd0;
            r.tens  = (c.tens == DIGIT_MAX) ? 4'd0 : c.tens + 4'd1;
        end else begin
            r.units = c.units + 4'd1;
        end
        return r;
    endfunction

    // Count down with wrap from 0 to 99
    function automatic t_bcd bcd_down(input t_bcd c);
        t_bcd r;
        r = c;
        if (c.units == 4'd0) begin
            r.units = DIGIT_MAX;
            r.tens  = (c.tens == 4'd0) ? DIGIT_MAX : c.tens - 4'd1;
        end else begin
            r.units = c.units - 4'd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/two_sensor_direction_counter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_sensor_direction_counter
// Bidirectional object counter on two infrared receivers, 0..99 with wrap.
// One scan is taken per clock while the scan queue is not full, and each
// gives one result beat. A scan accepted into an empty block is held in the
// scan queue behind the classifier, and the count engine writes it into the
// result queue at the edge that takes it out of there. Sustained rate is one
// scan per cycle while the result queue has room, set by the count engine,
// which updates its count and sensor state as it takes each scan. Both queues
// are QUEUE_DEPTH entries deep; the count starts at 0 after reset and
// thresholds at 70 and 30 percent (registers at byte offsets 0 and 4).
// ----------------------------------------------------------------------------
module two_sensor_direction_counter #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // scan side
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [7:0]                   i_sample_a,
    input  wire logic [7:0]                   i_sample_b,
    input  wire logic                         i_clear_press,
    input  wire logic                         i_down_press,
    input  wire logic                         i_up_press,
    // result side
    output logic                              empty,
    input  wire logic                         pop,
    output logic [3:0]                        o_tens_digit,
    output logic [3:0]                        o_units_digit,
    output logic                              o_obstacle_lamp,
    output logic                              o_relay_on,
    output logic                              o_store_strobe,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tsdc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [tsdc_pkg::APB_DW-1:0]  pwdata,
    output logic      [tsdc_pkg::APB_DW-1:0]  prdata,
    output logic                              pready
);
    import tsdc_pkg::*;

    logic [THR_W-1:0] r_high_threshold;
    logic [THR_W-1:0] r_low_threshold;
    logic             cfg_write;
    t_scan            front_scan;
    t_scan            mid_scan;
    logic             mid_empty;
    logic             mid_take;
    t_result          back_res;
    logic             back_push;
    logic             res_full;
    t_result          res_head;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_threshold <= HIGH_THR_RESET;
            r_low_threshold  <= LOW_THR_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_HIGH_THRESHOLD) begin
                r_high_threshold <= pwdata[THR_W-1:0];
            end
            if (paddr[2] == REG_LOW_THRESHOLD) begin
                r_low_threshold <= pwdata[THR_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HIGH_THRESHOLD) begin
            prdata[THR_W-1:0] = r_high_threshold;
        end else begin
            prdata[THR_W-1:0] = r_low_threshold;
        end
    end

    // Front: classify the scan
    tsdc_front u_front (
        .i_sample_a       (i_sample_a),
        .i_sample_b       (i_sample_b),
        .i_clear_press    (i_clear_press),
        .i_down_press     (i_down_press),
        .i_up_press       (i_up_press),
        .i_high_threshold (r_high_threshold),
        .i_low_threshold  (r_low_threshold),
        .o_scan           (front_scan)
    );

    // Queue of classified scans
    tsdc_fifo #(
        .WIDTH ($bits(t_scan)),
        .DEPTH (QUEUE_DEPTH)
    ) u_scan_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_scan),
        .o_full  (full),
        .i_pop   (mid_take),
        .o_data  (mid_scan),
        .o_empty (mid_empty)
    );

    // Back: count engine
    tsdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan       (mid_scan),
        .i_scan_valid (!mid_empty),
        .o_scan_take  (mid_take),
        .i_res_full   (res_full),
        .o_res        (back_res),
        .o_res_push   (back_push)
    );

    // Result queue
    tsdc_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_tens_digit    = res_head.tens_digit;
    assign o_units_digit   = res_head.units_digit;
    assign o_obstacle_lamp = res_head.obstacle_lamp;
    assign o_relay_on      = res_head.relay_on;
    assign o_store_strobe  = res_head.store_strobe;

`ifndef ASSERT_OFF
    // Relay follows a nonzero count
    a_relay_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_relay_on == ((o_tens_digit != 4'd0) || (o_units_digit != 4'd0))))
        else $error("relay does not match count");

    // Digits stay decimal
    a_digits_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_tens_digit <= DIGIT_MAX) && (o_units_digit <= DIGIT_MAX)))
        else $error("count digit out of range");

    // A waiting scan with room downstream shows up as a result next cycle
    a_scan_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!mid_empty && !res_full) |=> !empty)
        else $error("scan not carried to result queue");
`endif

endmodule
`default_nettype wire

/* rtl/tsdc_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsdc_fifo
// Small show-ahead queue with push/full and pop/empty sides. Used between
// front and back and as the result queue.
// ----------------------------------------------------------------------------
module tsdc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/tsdc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsdc_front
// Scan classifier: scales each sample to percent and judges it against the
// high and low thresholds; passes the button flags along.
// ----------------------------------------------------------------------------
module tsdc_front (
    input  wire logic [7:0]                  i_sample_a,
    input  wire logic [7:0]                  i_sample_b,
    input  wire logic                        i_clear_press,
    input  wire logic                        i_down_press,
    input  wire logic                        i_up_press,
    input  wire logic [tsdc_pkg::THR_W-1:0]  i_high_threshold,
    input  wire logic [tsdc_pkg::THR_W-1:0]  i_low_threshold,
    output tsdc_pkg::t_scan                  o_scan
);
    import tsdc_pkg::*;

    logic [25:0]      prod_a, prod_b;
    logic [THR_W-1:0] pct_a, pct_b;

    // Scale to percent by reciprocal multiply
    assign prod_a = {18'd0, i_sample_a} * {8'd0, PCT_MUL};
    assign prod_b = {18'd0, i_sample_b} * {8'd0, PCT_MUL};
    assign pct_a  = prod_a[PCT_SHIFT +: THR_W];
    assign pct_b  = prod_b[PCT_SHIFT +: THR_W];

    // Judge against thresholds
    always_comb begin
        o_scan.judge_a.above = (pct_a > i_high_threshold);
        o_scan.judge_a.below = (pct_a < i_low_threshold);
        o_scan.judge_b.above = (pct_b > i_high_threshold);
        o_scan.judge_b.below = (pct_b < i_low_threshold);
        o_scan.clear_press   = i_clear_press;
        o_scan.down_press    = i_down_press;
        o_scan.up_press      = i_up_press;
    end

endmodule
`default_nettype wire

/* rtl/tsdc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsdc_back
// Count engine: applies sensor levels, lamp, direction edges, store shadow and
// buttons, one scan per cycle while the result queue has room; emits results.
// ----------------------------------------------------------------------------
module tsdc_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  tsdc_pkg::t_scan i_scan,
    input  wire logic      i_scan_valid,
    output logic           o_scan_take,
    input  wire logic      i_res_full,
    output tsdc_pkg::t_result o_res,
    output logic           o_res_push
);
    import tsdc_pkg::*;

    logic r_level_a, n_level_a;
    logic r_level_b, n_level_b;
    logic r_lamp,    n_lamp;
    t_bcd r_count,   n_count;
    t_bcd r_stored;
    t_bcd sensed;
    logic strobe;
    logic fire;

    assign fire        = i_scan_valid && !i_res_full;
    assign o_scan_take = fire;
    assign o_res_push  = fire;

    // Work out the new state for this scan
    always_comb begin
        n_level_a = r_level_a;
        n_level_b = r_level_b;
        n_lamp    = r_lamp;

        // Hysteresis and lamp; sensor b goes last, low action after high
        if (i_scan.judge_a.above) begin
            n_level_a = 1'b1;
            n_lamp    = 1'b0;
        end
        if (i_scan.judge_a.below) begin
            n_level_a = 1'b0;
            n_lamp    = 1'b1;
        end
        if (i_scan.judge_b.above) begin
            n_level_b = 1'b1;
            n_lamp    = 1'b0;
        end
        if (i_scan.judge_b.below) begin
            n_level_b = 1'b0;
            n_lamp    = 1'b1;
        end

        // Direction edges
        sensed = r_count;
        if (n_level_a && !r_level_a && !n_level_b) begin
            sensed = bcd_up(r_count);
        end else if (n_level_b && !r_level_b && !n_level_a) begin
            sensed = bcd_down(r_count);
        end

        // Buttons in order clear, down, up
        strobe  = (sensed != r_stored);
        n_count = sensed;
        if (i_scan.clear_press) begin
            n_count = '0;
            strobe  = 1'b1;
        end
        if (i_scan.down_press) begin
            n_count = bcd_down(n_count);
            strobe  = 1'b1;
        end
        if (i_scan.up_press) begin
            n_count = bcd_up(n_count);
            strobe  = 1'b1;
        end

        o_res.tens_digit    = n_count.tens;
        o_res.units_digit   = n_count.units;
        o_res.obstacle_lamp = n_lamp;
        o_res.relay_on      = (n_count != '0);
        o_res.store_strobe  = strobe;
    end

    // Commit on each scan beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_a <= 1'b0;
            r_level_b <= 1'b0;
            r_lamp    <= 1'b0;
            r_count   <= '0;
            r_stored  <= '0;
        end else if (fire) begin
            r_level_a <= n_level_a;
            r_level_b <= n_level_b;
            r_lamp    <= n_lamp;
            r_count   <= n_count;
            r_stored  <= sensed;
        end
    end

endmodule
`default_nettype wire
